// File: sv/asd_pkg.sv
// asd_pkg: shared constants and types of the abelian square detector
// used by asd_cell, asd_penc and abelian_square_detector; no dependencies
`default_nettype none

package asd_pkg;

    localparam int MAX_PERIOD  = 40;
    localparam int HIST_DEPTH  = 2 * MAX_PERIOD;
    localparam int NUM_LETTERS = 4;
    localparam int SYM_W       = 2;
    localparam int CFG_W       = 6;
    localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
    localparam int PER_W       = $clog2(MAX_PERIOD + 1);
    localparam int DIFF_W      = $clog2(2 * MAX_PERIOD + 1);
    localparam int OUT_PER_W   = 6;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(40);

    // control handed to every cell with an accepted symbol
    typedef struct packed {
        logic              en;
        logic              fresh;
        logic [SYM_W-1:0]  sym;
        logic [FILL_W-1:0] fill_pre;
        logic [FILL_W-1:0] fill_post;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/abelian_square_detector.sv
// abelian_square_detector: top level, chain of period cells and result stage
// depends on asd_pkg, asd_cell, asd_penc
//
// usage
//   input stream: one quaternary letter per transaction in i_s_tdata, i_s_tuser
//   marks the first letter of a new word. output stream: one transaction per
//   input letter, in order, telling whether an abelian square of period
//   2..max_period ends at that letter, the shortest such period and the
//   sticky "no square yet" flag of the word.
//   cfg channel writes max_period (reset value 40, clamped to 40, values
//   below 2 disable detection); write it only while the block is idle.
//   the cells register the matches of each accepted letter, and the output
//   register takes the shortest matching period from them.
//   throughput: one letter per cycle while the output is not stalled; every
//   period has its own cell that updates its letter count difference in the
//   same cycle, and the shortest period is picked from the registered matches.
//   a stalled output holds both stages; o_s_tready drops until the output
//   register is taken.
//   reset (synchronous, active low) empties the pipe, restores max_period,
//   starts a new word and sets the clean flag; no clearing pass is needed.
`default_nettype none

module abelian_square_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [1:0] symbol, [7:2] zero
    input  wire logic [asd_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [0] start_word
    input  wire logic [0:0]                        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [0] square_ends_here, [6:1] shortest_period, [7] clean_so_far
    output logic      [asd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [asd_pkg::CFG_W-1:0]         i_cfg_data
);
    import asd_pkg::*;

    logic [CFG_W-1:0]     r_max_period;
    logic [FILL_W-1:0]    r_fill;
    logic                 r_pend;
    logic                 r_pend_start;
    logic                 r_clean;
    logic                 r_out_valid;
    logic                 r_out_sq;
    logic [PER_W-1:0]     r_out_per;
    logic                 r_out_clean;

    logic                 w_advance;
    logic                 w_accept;
    logic                 w_fresh;
    logic [FILL_W-1:0]    w_fill_pre;
    logic [FILL_W-1:0]    w_fill_post;
    t_cell_ctl            w_ctl;
    logic [SYM_W-1:0]     w_hist [HIST_DEPTH];
    logic [MAX_PERIOD-1:0] w_match;
    logic                 w_found;
    logic [PER_W-1:0]     w_period;
    logic                 n_clean;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && w_advance;
    assign o_s_tready = w_advance;
    assign o_cfg_ready = 1'b1;

    assign w_fresh     = i_s_tuser[0] || (r_fill == '0);
    assign w_fill_pre  = w_fresh ? '0 : r_fill;
    assign w_fill_post = (w_fill_pre == FILL_W'(HIST_DEPTH)) ? w_fill_pre : w_fill_pre + 1'b1;

    assign w_ctl.en        = w_accept;
    assign w_ctl.fresh     = w_fresh;
    assign w_ctl.sym       = i_s_tdata[SYM_W-1:0];
    assign w_ctl.fill_pre  = w_fill_pre;
    assign w_ctl.fill_post = w_fill_post;

    // cell p holds history slots 2p-2 and 2p-1, newest first
    for (genvar p = 1; p <= MAX_PERIOD; p++) begin : g_cell
        logic [SYM_W-1:0] w_feed;

        if (p == 1) begin : g_head
            assign w_feed = i_s_tdata[SYM_W-1:0];
        end else begin : g_link
            assign w_feed = w_hist[2*p-3];
        end

        asd_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_period   (PER_W'(p)),
            .i_sym_in   (w_feed),
            .i_tap_near (w_hist[p-1]),
            .i_tap_far  (w_hist[2*p-1]),
            .o_slot0    (w_hist[2*p-2]),
            .o_slot1    (w_hist[2*p-1]),
            .o_match    (w_match[p-1])
        );
    end

    asd_penc u_penc (
        .i_match      (w_match),
        .i_max_period (r_max_period),
        .o_found      (w_found),
        .o_period     (w_period)
    );

    assign n_clean = (r_pend_start || r_clean) && !w_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_period <= CFG_RESET;
            r_fill       <= '0;
            r_pend       <= 1'b0;
            r_pend_start <= 1'b0;
            r_clean      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_period <= i_cfg_data;
            end
            if (w_accept) begin
                r_fill <= w_fill_post;
            end
            if (w_advance) begin
                r_pend       <= w_accept;
                r_pend_start <= i_s_tuser[0];
                r_out_valid  <= r_pend;
                if (r_pend) begin
                    r_clean <= n_clean;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_pend) begin
            r_out_sq    <= w_found;
            r_out_per   <= w_found ? w_period : '0;
            r_out_clean <= n_clean;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_clean, OUT_PER_W'(r_out_per), r_out_sq};

    // result fields agree with each other
    a_sq_has_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sq |-> r_out_per >= PER_W'(2))
        else $error("square reported without a valid period");

    a_no_sq_no_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_sq |-> r_out_per == '0)
        else $error("period given without a square");

    a_sq_not_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sq |-> !r_out_clean)
        else $error("clean flag set at a square");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_clean_falls_on_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clean) |-> $past(r_pend && w_advance && w_found))
        else $error("clean flag cleared without a square");

endmodule

`default_nettype wire

// File: sv/asd_cell.sv
// asd_cell: one period of the chain; two history slots and the letter count difference
// depends on asd_pkg
`default_nettype none

module asd_cell (
    input  wire logic                       i_clk,
    input  wire asd_pkg::t_cell_ctl         i_ctl,
    input  wire logic [asd_pkg::PER_W-1:0]  i_period,
    input  wire logic [asd_pkg::SYM_W-1:0]  i_sym_in,
    input  wire logic [asd_pkg::SYM_W-1:0]  i_tap_near,
    input  wire logic [asd_pkg::SYM_W-1:0]  i_tap_far,
    output logic      [asd_pkg::SYM_W-1:0]  o_slot0,
    output logic      [asd_pkg::SYM_W-1:0]  o_slot1,
    output logic                            o_match
);
    import asd_pkg::*;

    logic [SYM_W-1:0]  r_slot0;
    logic [SYM_W-1:0]  r_slot1;
    logic [DIFF_W-1:0] r_d [NUM_LETTERS];
    logic [DIFF_W-1:0] n_d [NUM_LETTERS];
    logic              r_match;
    logic              n_match;
    logic [FILL_W-1:0] w_once;
    logic [FILL_W-1:0] w_twice;
    logic              w_near_ok;
    logic              w_far_ok;

    assign w_once    = FILL_W'(i_period);
    assign w_twice   = FILL_W'({i_period, 1'b0});
    assign w_near_ok = (i_ctl.fill_pre >= w_once);
    assign w_far_ok  = (i_ctl.fill_pre >= w_twice);

    // near half gains the new symbol and loses tap p-1 to the far half,
    // far half loses tap 2p-1
    always_comb begin
        logic [DIFF_W-1:0] base;
        logic              all_zero;
        all_zero = 1'b1;
        for (int c = 0; c < NUM_LETTERS; c++) begin
            base = i_ctl.fresh ? '0 : r_d[c];
            n_d[c] = base
                   + DIFF_W'(i_ctl.sym == SYM_W'(c))
                   - DIFF_W'({(w_near_ok && i_tap_near == SYM_W'(c)), 1'b0})
                   + DIFF_W'(w_far_ok && i_tap_far == SYM_W'(c));
            if (n_d[c] != '0) begin
                all_zero = 1'b0;
            end
        end
        n_match = all_zero && (i_ctl.fill_post >= w_twice);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_slot0 <= i_sym_in;
            r_slot1 <= r_slot0;
            r_d     <= n_d;
            r_match <= n_match;
        end
    end

    assign o_slot0 = r_slot0;
    assign o_slot1 = r_slot1;
    assign o_match = r_match;

endmodule

`default_nettype wire

// File: sv/asd_penc.sv
// asd_penc: shortest matching period within the configured limit
// depends on asd_pkg
`default_nettype none

module asd_penc (
    input  wire logic [asd_pkg::MAX_PERIOD-1:0] i_match,
    input  wire logic [asd_pkg::CFG_W-1:0]      i_max_period,
    output logic                                o_found,
    output logic      [asd_pkg::PER_W-1:0]      o_period
);
    import asd_pkg::*;

    localparam int NGRP = (MAX_PERIOD + 7) / 8;
    localparam int LIM_W = (PER_W > CFG_W) ? PER_W + 1 : CFG_W + 1;

    logic [LIM_W-1:0]    w_limit;
    logic [NGRP*8-1:0]   w_mask;
    logic [NGRP-1:0]     w_any;
    logic [2:0]          w_idx [NGRP];

    assign w_limit = (LIM_W'(i_max_period) > LIM_W'(MAX_PERIOD))
                   ? LIM_W'(MAX_PERIOD) : LIM_W'(i_max_period);

    // bit j stands for period j+1
    always_comb begin
        w_mask = '0;
        for (int j = 0; j < MAX_PERIOD; j++) begin
            w_mask[j] = i_match[j] && (j >= 1) && (LIM_W'(j + 1) <= w_limit);
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_any[g] = |w_mask[g*8 +: 8];
            w_idx[g] = '0;
            for (int k = 7; k >= 0; k--) begin
                if (w_mask[g*8 + k]) begin
                    w_idx[g] = 3'(k);
                end
            end
        end
    end

    always_comb begin
        o_found  = |w_any;
        o_period = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_any[g]) begin
                o_period = PER_W'(g * 8 + int'(w_idx[g]) + 1);
            end
        end
    end

endmodule

`default_nettype wire
